// ----- hw/rtl/wrle_pkg.sv -----
// shared types and constants for the word run-length decoder
// no dependencies
package wrle_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned PAGE_CNT_W  = 5;
    localparam int unsigned ADDR_W      = 20;
    localparam int unsigned NEXT_ADDR_W = 21;
    localparam int unsigned LIT_W       = 15;
    localparam int unsigned PAGE_BITS   = 16;

    localparam logic [PAGE_CNT_W-1:0] PAGE_CNT_RESET = 5'd8;
    localparam logic [PAGE_CNT_W-1:0] MAX_PAGES      = 5'd16;

    typedef enum logic [1:0] {
        PH_CMD = 2'd0,
        PH_RUN = 2'd1,
        PH_LIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              restart;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [WORD_W-1:0] write_value;
        logic [WORD_W-1:0] run_length;
        logic              fill_done;
    } t_result;

endpackage

// ----- hw/rtl/wrle_in_stage.sv -----
// input register for stream words
// depends on wrle_pkg
module wrle_in_stage
    import wrle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_step,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_ready = !r_valid || i_step;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_step) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hw/rtl/wrle_decode.sv -----
// decoder state and per-word step logic: command parsing, clipping, address update
// depends on wrle_pkg
module wrle_decode
    import wrle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  t_item                 i_item,
    input  logic [PAGE_CNT_W-1:0] i_page_count,
    output logic                  o_emit,
    output t_result               o_result
);

    t_phase                 r_phase, n_phase;
    logic [LIT_W-1:0]       r_lit_left, n_lit_left;
    logic [WORD_W-1:0]      r_pending_run, n_pending_run;
    logic [NEXT_ADDR_W-1:0] r_next_addr, n_next_addr;
    logic                   r_stopped, n_stopped;

    t_phase                 cur_phase;
    logic [LIT_W-1:0]       cur_lit;
    logic [WORD_W-1:0]      cur_run;
    logic [NEXT_ADDR_W-1:0] cur_addr;
    logic                   cur_stopped;
    logic [PAGE_CNT_W-1:0]  pages;
    logic [NEXT_ADDR_W-1:0] limit;
    logic [NEXT_ADDR_W-1:0] remaining;
    logic [NEXT_ADDR_W-1:0] req_len;
    logic [NEXT_ADDR_W-1:0] len;
    logic                   clipped;
    logic                   emit;
    logic [LIT_W-1:0]       lit_dec;
    logic [WORD_W-1:0]      word;

    assign word = i_item.data_word;

    always_comb begin
        // restart clears state before this word is looked at
        cur_phase   = i_item.restart ? PH_CMD : r_phase;
        cur_lit     = i_item.restart ? '0 : r_lit_left;
        cur_run     = i_item.restart ? '0 : r_pending_run;
        cur_addr    = i_item.restart ? '0 : r_next_addr;
        cur_stopped = i_item.restart ? 1'b0 : r_stopped;

        pages     = (i_page_count > MAX_PAGES) ? MAX_PAGES : i_page_count;
        limit     = {pages, {PAGE_BITS{1'b0}}};
        remaining = limit - cur_addr;
        lit_dec   = cur_lit - 1'b1;

        n_phase       = cur_phase;
        n_lit_left    = cur_lit;
        n_pending_run = cur_run;
        n_next_addr   = cur_addr;
        n_stopped     = cur_stopped;
        emit          = 1'b0;
        req_len       = '0;

        if (!cur_stopped && (cur_addr < limit)) begin
            unique case (cur_phase)
                PH_RUN: begin
                    n_phase = PH_CMD;
                    emit    = 1'b1;
                    req_len = NEXT_ADDR_W'(cur_run);
                end
                PH_LIT: begin
                    n_lit_left = lit_dec;
                    if (lit_dec == '0) begin
                        n_phase = PH_CMD;
                    end
                    emit    = 1'b1;
                    req_len = NEXT_ADDR_W'(1);
                end
                default: begin
                    if (word[WORD_W-1]) begin
                        // negative command: run of its magnitude, -32768 gives 32768
                        n_pending_run = WORD_W'(17'h10000 - {1'b0, word});
                        n_phase       = PH_RUN;
                    end else if (word != '0) begin
                        n_lit_left = word[LIT_W-1:0];
                        n_phase    = PH_LIT;
                    end else begin
                        n_phase = PH_CMD;
                    end
                end
            endcase
        end

        clipped = emit && (req_len >= remaining);
        len     = clipped ? remaining : req_len;
        if (emit) begin
            n_next_addr = cur_addr + len;
            if (clipped) begin
                n_stopped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_CMD;
            r_lit_left    <= '0;
            r_pending_run <= '0;
            r_next_addr   <= '0;
            r_stopped     <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_lit_left    <= n_lit_left;
            r_pending_run <= n_pending_run;
            r_next_addr   <= n_next_addr;
            r_stopped     <= n_stopped;
        end
    end

    assign o_emit                 = emit;
    assign o_result.write_address = cur_addr[ADDR_W-1:0];
    assign o_result.write_value   = word;
    assign o_result.run_length    = len[WORD_W-1:0];
    assign o_result.fill_done     = clipped;

endmodule

// ----- hw/rtl/wrle_out_stage.sv -----
// result register toward the write side
// depends on wrle_pkg
module wrle_out_stage
    import wrle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_emit,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= i_emit;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hw/rtl/word_rle_decoder_unit.sv -----
// word run-length decoder: input stage register, then decode step, then output stage register
// throughput one word per cycle while the write side keeps taking results
// the decoder state loop (phase, counts, next address) is one register set, updated on each step
// sync active-low reset: phase to expect command, address 0, not stopped, 8 pages
// depends on wrle_pkg, wrle_in_stage, wrle_decode, wrle_out_stage
module word_rle_decoder_unit
    import wrle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config
    input  logic                  i_cfg_we,
    input  logic [PAGE_CNT_W-1:0] i_cfg_data,
    // stream word in
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [WORD_W-1:0]     i_data_word,
    input  logic                  i_restart,
    // write result out
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ADDR_W-1:0]     o_write_address,
    output logic [WORD_W-1:0]     o_write_value,
    output logic [WORD_W-1:0]     o_run_length,
    output logic                  o_fill_done
);

    logic [PAGE_CNT_W-1:0] r_page_count;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    step;
    logic    emit;
    t_result step_result;
    t_result out_result;

    // page count register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= PAGE_CNT_RESET;
        end else if (i_cfg_we) begin
            r_page_count <= i_cfg_data;
        end
    end

    assign in_item.data_word = i_data_word;
    assign in_item.restart   = i_restart;

    // held word is processed once the result register can take its output
    assign step = held_valid && out_free;

    wrle_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_step  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // classify word, clip against fill limit, advance address
    wrle_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_item       (held_item),
        .i_page_count (r_page_count),
        .o_emit       (emit),
        .o_result     (step_result)
    );

    wrle_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_emit   (emit),
        .i_result (step_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_write_address = out_result.write_address;
    assign o_write_value   = out_result.write_value;
    assign o_run_length    = out_result.run_length;
    assign o_fill_done     = out_result.fill_done;

endmodule

// ----- dv/tb_word_rle_decoder_unit.sv -----
// self-checking testbench for word_rle_decoder_unit: stream words in, run writes out
// predicts every write from the stream and compares it field by field at the output
// depends on wrle_pkg and the word_rle_decoder_unit rtl
`timescale 1ns / 1ps

module tb_word_rle_decoder_unit;
    import wrle_pkg::*;

    // pause after the last write before touching config or ending the run
    localparam int DRAIN_CYCLES = 8;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES = 300;
    // a run command word is 0x10000 minus the run length
    localparam logic [16:0] RUN_BASE = 17'h10000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [PAGE_CNT_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [WORD_W-1:0]     i_data_word;
    logic                  i_restart;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [ADDR_W-1:0]     o_write_address;
    logic [WORD_W-1:0]     o_write_value;
    logic [WORD_W-1:0]     o_run_length;
    logic                  o_fill_done;

    word_rle_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_word     (i_data_word),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_run_length    (o_run_length),
        .o_fill_done     (o_fill_done)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // generous fixed limit on the whole run
    initial begin
        #5_000_000;
        $display("tb_word_rle_decoder_unit: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // decoder prediction: own copy of the page setting and stream state
    // ---------------------------------------------------------------
    logic [PAGE_CNT_W-1:0]  pages_cfg;
    t_phase                 dec_phase;
    logic [LIT_W-1:0]       lit_left;
    logic [16:0]            run_pend;
    logic [NEXT_ADDR_W-1:0] next_addr;
    bit                     halted;

    // writes predicted but not yet seen at the output, oldest first
    t_result expected_writes[$];

    int  mismatch_cnt = 0;
    int  taken_words  = 0;   // words the decoder actually acted on
    bit  last_ignored = 1'b0;

    // idling controls shared with the receiver process
    bit  no_idle  = 1'b0;
    int  hold_req = 0;

    function automatic bit decode_word(input logic [WORD_W-1:0] w, input logic rs,
                                       output t_result res, output bit ign);
        logic [PAGE_CNT_W-1:0]  pages;
        logic [NEXT_ADDR_W-1:0] limit;
        logic [NEXT_ADDR_W-1:0] room;
        logic [NEXT_ADDR_W-1:0] len;
        res = '0;
        ign = 1'b0;
        len = '0;
        // restart clears the stream and takes this word as its first command
        if (rs) begin
            dec_phase = PH_CMD;
            lit_left  = '0;
            run_pend  = '0;
            next_addr = '0;
            halted    = 1'b0;
        end
        // page count saturates, zero pages means nothing is ever written
        pages = (pages_cfg > MAX_PAGES) ? MAX_PAGES : pages_cfg;
        limit = NEXT_ADDR_W'(pages) << PAGE_BITS;
        if (halted || next_addr >= limit) begin
            ign = 1'b1;
            return 1'b0;
        end
        case (dec_phase)
            PH_RUN: begin
                dec_phase = PH_CMD;
                len = NEXT_ADDR_W'(run_pend);
            end
            PH_LIT: begin
                lit_left = lit_left - 1'b1;
                if (lit_left == '0) begin
                    dec_phase = PH_CMD;
                end
                len = NEXT_ADDR_W'(1);
            end
            default: begin
                // command word: bit 15 set is a run, else a literal count, zero is a no-op
                if (w[WORD_W-1]) begin
                    run_pend  = RUN_BASE - {1'b0, w};
                    dec_phase = PH_RUN;
                end else if (w != '0) begin
                    lit_left  = w[LIT_W-1:0];
                    dec_phase = PH_LIT;
                end else begin
                    dec_phase = PH_CMD;
                end
                return 1'b0;
            end
        endcase
        // clip at the fill limit; the write that reaches it ends decoding
        room = limit - next_addr;
        if (len >= room) begin
            len           = room;
            res.fill_done = 1'b1;
            halted        = 1'b1;
        end
        res.write_address = next_addr[ADDR_W-1:0];
        res.write_value   = w;
        res.run_length    = len[WORD_W-1:0];
        next_addr         = next_addr + len;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // idle lengths: mostly short, a few long
    // ---------------------------------------------------------------
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_send_gap();
        if (no_idle || $urandom_range(0, 99) < 65) begin
            return 0;
        end
        return pick_idle_len();
    endfunction

    // ---------------------------------------------------------------
    // write side: random ready, quiet stretches, and a long hold on request
    // ---------------------------------------------------------------
    int hold_ack   = 0;
    int hold_left  = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            stall_left = pick_idle_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // write checker: sampled mid-cycle, the handshake completes at the next edge
    // ---------------------------------------------------------------
    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%s: exp addr=%h val=%h len=%0d done=%b | got addr=%h val=%h len=%0d done=%b",
                     what, want.write_address, want.write_value, want.run_length,
                     want.fill_done, got.write_address, got.write_value, got.run_length,
                     got.fill_done);
        end
    endtask

    always @(negedge i_clk) begin : write_check
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            got.write_address = o_write_address;
            got.write_value   = o_write_value;
            got.run_length    = o_run_length;
            got.fill_done     = o_fill_done;
            if (expected_writes.size() == 0) begin
                note_mismatch("write with none expected", '0, got);
            end else begin
                want = expected_writes.pop_front();
                if (got.write_address !== want.write_address ||
                    got.write_value   !== want.write_value   ||
                    got.run_length    !== want.run_length    ||
                    got.fill_done     !== want.fill_done) begin
                    note_mismatch("write mismatch", want, got);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stream side helpers, always entered right after a rising edge
    // ---------------------------------------------------------------
    task automatic send_word(input logic [WORD_W-1:0] w, input logic rs);
        int      gap;
        t_result res;
        bit      ign;
        gap = pick_send_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_word <= w;
        i_restart   <= rs;
        do @(negedge i_clk); while (o_in_ready !== 1'b1);
        @(posedge i_clk);
        // word taken at this edge
        if (decode_word(w, rs, res, ign)) begin
            expected_writes.push_back(res);
        end
        last_ignored = ign;
        if (!ign) begin
            taken_words++;
        end
    endtask

    // run command for n words, 1..32768, then the value to repeat
    task automatic send_run(input int n, input logic [WORD_W-1:0] v, input logic rs);
        logic [16:0] cmd;
        cmd = RUN_BASE - 17'(n);
        send_word(cmd[WORD_W-1:0], rs);
        send_word(v, 1'b0);
    endtask

    // stop offering words, wait for every predicted write, then let the pipe settle
    task automatic wait_writes_drained();
        i_in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic set_pages(input logic [PAGE_CNT_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        pages_cfg = v;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset page count, every command kind, field extremes, restart mid-command
    task automatic test_commands();
        send_word(16'h0003, 1'b1);          // literal of three
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);          // zero command, no write
        send_run(1, 16'h5A5A, 1'b0);        // shortest run
        send_run(32768, 16'h1234, 1'b0);    // most negative command, longest run
        send_word(16'h7FFF, 1'b0);          // longest literal, cut short below
        send_word(16'hC3C3, 1'b0);
        send_word(16'h3C3C, 1'b0);
        send_word(16'h0001, 1'b1);          // restart mid-literal
        send_word(16'hABCD, 1'b0);
        send_word(16'hFFF0, 1'b0);          // run command, then restart before its value
        send_word(16'h0000, 1'b1);
        send_run(2, 16'h0F0F, 1'b0);
        wait_writes_drained();
    endtask

    // exact fill, ignoring after done, then a clipped run
    task automatic test_fill_clip();
        set_pages(5'd1);
        send_run(32768, 16'h1111, 1'b1);
        send_run(32768, 16'h2222, 1'b0);    // lands exactly on the limit
        send_word(16'hFFFE, 1'b0);          // ignored after done
        send_word(16'h1111, 1'b0);
        send_run(16384, 16'h3333, 1'b1);
        send_run(32768, 16'h4444, 1'b0);
        send_run(32768, 16'h5555, 1'b0);    // cut to the remaining words
        wait_writes_drained();
    endtask

    // zero pages: nothing is ever written
    task automatic test_zero_pages();
        set_pages(5'd0);
        send_run(4, 16'h6666, 1'b1);
        send_word(16'h0002, 1'b1);
        send_word(16'h7777, 1'b0);
        wait_writes_drained();
    endtask

    // lowering the page count below the current address stalls decoding in place
    task automatic test_limit_lowered();
        set_pages(5'd2);
        send_run(32768, 16'h0101, 1'b1);
        send_run(32768, 16'h0202, 1'b0);
        send_run(32768, 16'h0303, 1'b0);
        send_word(16'hFFFC, 1'b0);          // run of four waits for its value
        wait_writes_drained();
        set_pages(5'd1);
        send_word(16'h2222, 1'b0);          // past the limit, ignored
        wait_writes_drained();
        set_pages(5'd2);
        send_word(16'h3333, 1'b0);          // pending run resumes
        wait_writes_drained();
    endtask

    // long receiver hold while words keep coming, so the input backs up
    task automatic test_backpressure();
        set_pages(5'd8);
        hold_req++;
        send_word(16'd40, 1'b1);
        repeat (40) send_word(WORD_W'($urandom_range(0, 65535)), 1'b0);
        wait_writes_drained();
    endtask

    // one page setting, mostly well-formed commands with random content, some noise
    task automatic random_phase(input logic [PAGE_CNT_W-1:0] pages, input int target,
                                input int run_pct, input int big_pct, input bit quiet);
        int   base;
        int   n;
        logic rs;
        set_pages(pages);
        no_idle = quiet;
        base    = taken_words;
        while (taken_words - base < target) begin
            // restart once the stream has stopped, sometimes anyway
            rs = last_ignored || ($urandom_range(0, 99) < 6);
            if ($urandom_range(0, 99) < 12) begin
                send_word(WORD_W'($urandom_range(0, 65535)), ($urandom_range(0, 99) < 10));
            end else if ($urandom_range(0, 99) < run_pct) begin
                if ($urandom_range(0, 99) < big_pct) begin
                    n = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(16384, 32768);
                end else begin
                    n = $urandom_range(1, 16);
                end
                send_run(n, WORD_W'($urandom_range(0, 65535)), rs);
            end else if ($urandom_range(0, 99) < 95) begin
                n = $urandom_range(1, 8);
                send_word(WORD_W'(n), rs);
                repeat (n) send_word(WORD_W'($urandom_range(0, 65535)), 1'b0);
            end else begin
                send_word(16'h0000, rs);
            end
        end
        no_idle = 1'b0;
        wait_writes_drained();
    endtask

    task automatic test_random_stream();
        random_phase(5'd1, 100, 40, 20, 1'b0);
        random_phase(5'd31, 150, 90, 100, 1'b1);   // saturates to the top page count
        random_phase(5'd16, 150, 90, 100, 1'b0);
        repeat (5) begin
            random_phase(PAGE_CNT_W'($urandom_range(1, 31)), 80, 45, 20,
                         ($urandom_range(0, 2) == 0));
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_data_word = '0;
        i_restart   = 1'b0;
        pages_cfg   = PAGE_CNT_RESET;
        dec_phase   = PH_CMD;
        lit_left    = '0;
        run_pend    = '0;
        next_addr   = '0;
        halted      = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands();
        test_fill_clip();
        test_zero_pages();
        test_limit_lowered();
        test_backpressure();
        test_random_stream();

        wait_writes_drained();
        if (expected_writes.size() != 0) begin
            $display("writes still expected at end: %0d", expected_writes.size());
        end
        if (mismatch_cnt == 0 && expected_writes.size() == 0) begin
            $display("tb_word_rle_decoder_unit: PASS");
        end else begin
            $display("tb_word_rle_decoder_unit: FAIL");
        end
        $finish;
    end

endmodule
